>>> sv/lhlm_pkg.sv
// package for the low half limb multiplier
// sizes, control structs, sequencer states and partial product codes
// no dependencies
package lhlm_pkg;

   localparam int MAX_LIMBS  = 32;
   localparam int LIMB_BITS  = 64;
   localparam int FIELD_BITS = 64;
   localparam int POS_BITS   = 5;
   localparam int IDX_BITS   = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_LIMBS + 1);
   localparam int HALF_BITS  = (LIMB_BITS + 1) / 2;
   localparam int EXT_BITS   = 2 * HALF_BITS;
   localparam int PROD_BITS  = 2 * HALF_BITS;
   // column sum plus carry stays below 2^(2*LIMB_BITS+7)
   localparam int ACC_BITS   = 2 * LIMB_BITS + 8;
   localparam int CARRY_BITS = ACC_BITS - LIMB_BITS;

   typedef logic [LIMB_BITS-1:0] limb_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_DRAIN,
      S_DONE
   } seq_state_type;

   // which half-by-half product of the two limbs
   typedef enum logic [1:0] {
      PART_LL,
      PART_LH,
      PART_HL,
      PART_HH
   } part_type;

   typedef struct packed {
      logic     init;
      logic     mul;
      part_type part;
      logic     commit;
      logic     clear;
   } mac_ctrl_type;

   typedef struct packed {
      logic    wr_en;
      idx_type wr_addr;
      logic    rd_en;
      idx_type a_addr;
      idx_type b_addr;
   } ram_ctrl_type;

   typedef struct packed {
      logic                done;
      logic                ovf;
      logic                last;
      logic [POS_BITS-1:0] pos;
   } seq_status_type;

endpackage

>>> sv/lhlm_limb_ram.sv
// operand limb store: one write port, one registered read port
// depends on lhlm_pkg
module lhlm_limb_ram (
   input  logic               clock,
   input  logic               wr_en,
   input  lhlm_pkg::idx_type  wr_addr,
   input  lhlm_pkg::limb_type wr_data,
   input  logic               rd_en,
   input  lhlm_pkg::idx_type  rd_addr,
   output lhlm_pkg::limb_type rd_data
);
   import lhlm_pkg::*;

   limb_type mem_ff [MAX_LIMBS];
   limb_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lhlm_mac.sv
// shared multiply-accumulate unit: one half-width multiplier, column accumulator
// and the carry into the next column; depends on lhlm_pkg
module lhlm_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  lhlm_pkg::mac_ctrl_type ctrl,
   input  lhlm_pkg::limb_type     a_word,
   input  lhlm_pkg::limb_type     b_word,
   output lhlm_pkg::limb_type     acc_low
);
   import lhlm_pkg::*;

   logic [EXT_BITS-1:0]   a_ext;
   logic [EXT_BITS-1:0]   b_ext;
   logic [HALF_BITS-1:0]  x_sel;
   logic [HALF_BITS-1:0]  y_sel;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                  pend_ff, pend_in;
   part_type              pend_part_ff, pend_part_in;
   logic [ACC_BITS-1:0]   addend;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [CARRY_BITS-1:0] carry_ff, carry_in;

   always_comb begin
      a_ext = EXT_BITS'(a_word);
      b_ext = EXT_BITS'(b_word);
      case (ctrl.part)
         PART_LL: begin
            x_sel = a_ext[HALF_BITS-1:0];
            y_sel = b_ext[HALF_BITS-1:0];
         end
         PART_LH: begin
            x_sel = a_ext[HALF_BITS-1:0];
            y_sel = b_ext[EXT_BITS-1:HALF_BITS];
         end
         PART_HL: begin
            x_sel = a_ext[EXT_BITS-1:HALF_BITS];
            y_sel = b_ext[HALF_BITS-1:0];
         end
         PART_HH: begin
            x_sel = a_ext[EXT_BITS-1:HALF_BITS];
            y_sel = b_ext[EXT_BITS-1:HALF_BITS];
         end
         default: begin
            x_sel = '0;
            y_sel = '0;
         end
      endcase

      prod_in      = ctrl.mul ? (PROD_BITS'(x_sel) * PROD_BITS'(y_sel)) : prod_ff;
      pend_in      = ctrl.mul;
      pend_part_in = ctrl.part;

      // weight of the product registered last cycle
      case (pend_part_ff)
         PART_LL: addend = ACC_BITS'(prod_ff);
         PART_LH: addend = ACC_BITS'(prod_ff) << HALF_BITS;
         PART_HL: addend = ACC_BITS'(prod_ff) << HALF_BITS;
         PART_HH: addend = ACC_BITS'(prod_ff) << (2 * HALF_BITS);
         default: addend = '0;
      endcase

      acc_in = acc_ff;
      if (ctrl.init) begin
         acc_in = ACC_BITS'(carry_ff);
      end else if (pend_ff) begin
         acc_in = acc_ff + addend;
      end

      carry_in = carry_ff;
      if (ctrl.clear) begin
         carry_in = '0;
      end else if (ctrl.commit) begin
         carry_in = acc_ff[ACC_BITS-1:LIMB_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         carry_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      pend_part_ff <= pend_part_in;
      acc_ff       <= acc_in;
   end

   assign acc_low = acc_ff[LIMB_BITS-1:0];

endmodule

>>> sv/lhlm_seq.sv
// sequencer: walks the terms of one product column through the shared unit
// owns the limb count and drives store and unit control; depends on lhlm_pkg
module lhlm_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last_limb,
   input  logic                     out_free,
   output logic                     req_stall,
   output lhlm_pkg::mac_ctrl_type   mac_ctrl,
   output lhlm_pkg::ram_ctrl_type   ram_ctrl,
   output lhlm_pkg::seq_status_type status
);
   import lhlm_pkg::*;

   seq_state_type        state_ff, state_in;
   idx_type              j_ff, j_in;
   part_type             part_ff, part_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   idx_type              idx_i;
   logic                 room;
   logic                 accept;

   assign idx_i  = count_ff[IDX_BITS-1:0];
   assign room   = count_ff < CNT_BITS'(MAX_LIMBS);
   assign accept = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      part_ff <= part_in;
      ovf_ff  <= ovf_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      part_in  = part_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;

      req_stall = (state_ff != S_IDLE);

      mac_ctrl.init   = 1'b0;
      mac_ctrl.mul    = 1'b0;
      mac_ctrl.part   = part_ff;
      mac_ctrl.commit = 1'b0;
      mac_ctrl.clear  = 1'b0;

      ram_ctrl.wr_en   = 1'b0;
      ram_ctrl.wr_addr = idx_i;
      ram_ctrl.rd_en   = 1'b0;
      ram_ctrl.a_addr  = j_ff;
      ram_ctrl.b_addr  = idx_i - j_ff;

      status.done = (state_ff == S_DONE);
      status.ovf  = ovf_ff;
      status.last = last_ff;
      status.pos  = ovf_ff ? '0 : POS_BITS'(count_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ovf_in  = !room;
               last_in = req_last_limb;
               if (room) begin
                  ram_ctrl.wr_en = 1'b1;
                  mac_ctrl.init  = 1'b1;
                  j_in           = '0;
                  state_in       = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            ram_ctrl.rd_en = 1'b1;
            part_in        = PART_LL;
            state_in       = S_MUL;
         end
         S_MUL: begin
            mac_ctrl.mul = 1'b1;
            case (part_ff)
               PART_LL: part_in = PART_LH;
               PART_LH: part_in = PART_HL;
               PART_HL: part_in = PART_HH;
               default: begin
                  part_in = PART_LL;
                  if (j_ff == idx_i) begin
                     state_in = S_DRAIN;
                  end else begin
                     j_in     = j_ff + IDX_BITS'(1);
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_DRAIN: begin
            // last partial product lands in the accumulator
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
               if (last_ff) begin
                  mac_ctrl.clear = 1'b1;
                  count_in       = '0;
               end else if (!ovf_ff) begin
                  mac_ctrl.commit = 1'b1;
                  count_in        = count_ff + CNT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_full_goes_done: assert property (@(posedge clock) disable iff (reset)
      (accept && !room) |=> (state_ff == S_DONE && ovf_ff))
      else $error("transfer into a full store did not go straight to done");

   a_term_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && part_ff == PART_HH) |=> (state_ff == S_READ || state_ff == S_DRAIN))
      else $error("term did not end after four partial products");

   a_j_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_DONE && !ovf_ff) |-> (j_ff <= idx_i))
      else $error("term index ran past the column");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free && last_ff) |=> (count_ff == '0))
      else $error("limb count not cleared after final limb");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_LIMBS))
      else $error("limb count beyond store depth");

endmodule

>>> sv/low_half_limb_multiplier.sv
// low half limb multiplier: one product limb is returned on the response channel for every limb pair transferred in
// one 32x32 multiplier is shared: each term a_j*b_(i-j) takes one store read and four products
// a new limb pair is taken only after the product limb of the last one is loaded into the response register
// synchronous active-high reset clears the limb count, column carry and response valid
// operand stores are not cleared; only limbs of the current product are ever read
// depends on lhlm_pkg, lhlm_limb_ram, lhlm_mac, lhlm_seq
module low_half_limb_multiplier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lhlm_pkg::FIELD_BITS-1:0]       req_a_limb,
   input  logic [lhlm_pkg::FIELD_BITS-1:0]       req_b_limb,
   input  logic                                  req_last_limb,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lhlm_pkg::FIELD_BITS-1:0]       rsp_product_limb,
   output logic [lhlm_pkg::POS_BITS-1:0]         rsp_limb_position,
   output logic                                  rsp_is_last,
   output logic                                  rsp_overflow
);
   import lhlm_pkg::*;

   mac_ctrl_type        mac_ctrl;
   ram_ctrl_type        ram_ctrl;
   seq_status_type      status;
   limb_type            a_word;
   limb_type            b_word;
   limb_type            acc_low;
   logic                out_free;
   logic                out_load;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_limb_ff, rsp_limb_in;
   logic [POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   // response slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = status.done && out_free;

   // sequencer: input handshake, limb count, term and partial product steps
   lhlm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_limb (req_last_limb),
      .out_free      (out_free),
      .req_stall     (req_stall),
      .mac_ctrl      (mac_ctrl),
      .ram_ctrl      (ram_ctrl),
      .status        (status)
   );

   // first operand store, read at term index j
   lhlm_limb_ram u_a_ram (
      .clock   (clock),
      .wr_en   (ram_ctrl.wr_en),
      .wr_addr (ram_ctrl.wr_addr),
      .wr_data (req_a_limb[LIMB_BITS-1:0]),
      .rd_en   (ram_ctrl.rd_en),
      .rd_addr (ram_ctrl.a_addr),
      .rd_data (a_word)
   );

   // second operand store, read at i-j
   lhlm_limb_ram u_b_ram (
      .clock   (clock),
      .wr_en   (ram_ctrl.wr_en),
      .wr_addr (ram_ctrl.wr_addr),
      .wr_data (req_b_limb[LIMB_BITS-1:0]),
      .rd_en   (ram_ctrl.rd_en),
      .rd_addr (ram_ctrl.b_addr),
      .rd_data (b_word)
   );

   // shared multiplier, column accumulator and carry
   lhlm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_word  (a_word),
      .b_word  (b_word),
      .acc_low (acc_low)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_limb_in  = rsp_limb_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         // a limb dropped on overflow reads as zero
         rsp_limb_in  = status.ovf ? '0 : FIELD_BITS'(acc_low);
         rsp_pos_in   = status.pos;
         rsp_last_in  = status.last;
         rsp_ovf_in   = status.ovf;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_limb_ff <= rsp_limb_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_limb  = rsp_limb_ff;
   assign rsp_limb_position = rsp_pos_ff;
   assign rsp_is_last       = rsp_last_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for low_half_limb_multiplier: predicts each product limb
// from the limb pairs it transfers in, under random idling on both channels
// depends on lhlm_pkg and the low_half_limb_multiplier rtl
module testbench;

   localparam int FB = lhlm_pkg::FIELD_BITS;
   localparam int PB = lhlm_pkg::POS_BITS;
   localparam int LB = lhlm_pkg::LIMB_BITS;
   localparam int STORE_DEPTH = lhlm_pkg::MAX_LIMBS;
   // bits of a limb that take part in the product
   localparam logic [FB-1:0] LIMB_MASK = (LB >= FB) ? '1 : ((FB'(1) << LB) - FB'(1));
   localparam logic [FB-1:0] TOP_BIT = {1'b1, {(FB-1){1'b0}}};
   // about 950 limb pairs in all, the directed part included
   localparam int RANDOM_PAIRS = 935;
   // quiet time after the last product limb, longer than a full-store column takes
   localparam int TAIL_CYCLES = 200;
   // longest honest silence is a full-store column plus a long stall and a long gap
   localparam int SILENCE_LIMIT = 4000;

   // one expected product limb
   typedef struct {
      logic [FB-1:0] limb;
      logic [PB-1:0] position;
      logic          is_last;
      logic          overflow;
   } product_limb_type;

   // schoolbook low-half multiplier: keeps its own copy of the operand limbs,
   // the limb count and the carry between columns, and queues the limbs it expects
   class limb_product_scoreboard_type;
      logic [FB-1:0]    a_limbs [STORE_DEPTH];
      logic [FB-1:0]    b_limbs [STORE_DEPTH];
      int unsigned      limbs_held;
      logic [127:0]     column_carry;
      product_limb_type expected_limbs [$];
      int unsigned      errors;

      function new();
         limbs_held   = 0;
         column_carry = '0;
         errors       = 0;
      endfunction

      function int unsigned waiting();
         return expected_limbs.size();
      endfunction

      function void report(string what);
         $display("%0t ns  mismatch: %s", $time, what);
         errors++;
      endfunction

      // a limb pair was transferred in: form its column and queue the product limb
      function void take_limb_pair(logic [FB-1:0] a, logic [FB-1:0] b, logic last);
         product_limb_type want;
         logic [191:0]     column;
         int unsigned      j;
         want.limb     = '0;
         want.position = '0;
         want.is_last  = last;
         want.overflow = 1'b0;
         if (limbs_held >= STORE_DEPTH) begin
            // store full: pair dropped, count and carry kept
            want.overflow = 1'b1;
         end else begin
            a_limbs[limbs_held] = a & LIMB_MASK;
            b_limbs[limbs_held] = b & LIMB_MASK;
            column = {64'd0, column_carry};
            for (j = 0; j <= limbs_held; j++)
               column += 192'(a_limbs[j]) * 192'(b_limbs[limbs_held - j]);
            want.limb     = column[FB-1:0] & LIMB_MASK;
            column_carry  = 128'(column >> LB);
            want.position = PB'(limbs_held);
            limbs_held++;
         end
         if (last) begin
            limbs_held   = 0;
            column_carry = '0;
         end
         expected_limbs.push_back(want);
      endfunction

      // a product limb was transferred out: compare with the oldest expectation
      function void check_product_limb(logic [FB-1:0] limb, logic [PB-1:0] position,
                                       logic is_last, logic overflow);
         product_limb_type want;
         if (expected_limbs.size() == 0) begin
            report($sformatf("product limb %h with none pending", limb));
            return;
         end
         want = expected_limbs.pop_front();
         if (limb !== want.limb)
            report($sformatf("product_limb %h, want %h", limb, want.limb));
         if (position !== want.position)
            report($sformatf("limb_position %0d, want %0d", position, want.position));
         if (is_last !== want.is_last)
            report($sformatf("is_last %b, want %b", is_last, want.is_last));
         if (overflow !== want.overflow)
            report($sformatf("overflow %b, want %b", overflow, want.overflow));
      endfunction
   endclass

   // every input starts at a known value
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [FB-1:0] req_a_limb = '0;
   logic [FB-1:0] req_b_limb = '0;
   logic          req_last_limb = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [FB-1:0] rsp_product_limb;
   logic [PB-1:0] rsp_limb_position;
   logic          rsp_is_last;
   logic          rsp_overflow;

   // stretches with no idling on either side
   logic          no_idle = 1'b0;
   int unsigned   stall_left = 0;
   int unsigned   stall_roll;
   int unsigned   silent_cycles = 0;

   limb_product_scoreboard_type products;

   low_half_limb_multiplier dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_a_limb        (req_a_limb),
      .req_b_limb        (req_b_limb),
      .req_last_limb     (req_last_limb),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_limb  (rsp_product_limb),
      .rsp_limb_position (rsp_limb_position),
      .rsp_is_last       (rsp_is_last),
      .rsp_overflow      (rsp_overflow)
   );

   always #10 clock = ~clock;

   // limb values: extremes and single bits often, half-width randoms and their inverses, full random half the time
   function automatic logic [FB-1:0] pick_limb();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         2: return FB'(1);
         3: return TOP_BIT;
         4: return FB'($urandom());
         5: return ~FB'($urandom());
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // idle cycles before a transfer: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // offer one limb pair and hold it until it is transferred
   task automatic push_limb_pair(input logic [FB-1:0] a, input logic [FB-1:0] b,
                                 input logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_a_limb    <= a;
      req_b_limb    <= b;
      req_last_limb <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      products.take_limb_pair(a, b, last);
   endtask

   // response side back-pressure, in runs of random length
   always @(posedge clock) begin
      if (no_idle) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
         end else if (stall_roll < 92) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 60);
         end
      end
   end

   // output transfers are checked as they happen
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         products.check_product_limb(rsp_product_limb, rsp_limb_position,
                                     rsp_is_last, rsp_overflow);
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         silent_cycles <= 0;
      end else if (silent_cycles >= SILENCE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   initial begin
      int unsigned len;
      int unsigned k;
      int unsigned pairs_sent;
      int unsigned product_count;
      int unsigned roll;
      products = new();
      pairs_sent    = 0;
      product_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-limb products: all ones squared, a zero operand, one times one
      push_limb_pair('1, '1, 1'b1);
      push_limb_pair('0, '1, 1'b1);
      push_limb_pair(FB'(1), FB'(1), 1'b1);
      // three limbs of all ones, the carry feeds every column
      push_limb_pair('1, '1, 1'b0);
      push_limb_pair('1, '1, 1'b0);
      push_limb_pair('1, '1, 1'b1);
      // top bit only, products land across the limb boundary
      push_limb_pair(TOP_BIT, TOP_BIT, 1'b0);
      push_limb_pair(FB'(1), TOP_BIT, 1'b0);
      push_limb_pair(TOP_BIT, FB'(1), 1'b1);
      // checkerboard patterns
      push_limb_pair({16{4'h5}}, {16{4'ha}}, 1'b0);
      push_limb_pair({16{4'ha}}, {16{4'h5}}, 1'b0);
      push_limb_pair({4{16'hffff, 16'h0000}}, {4{16'h0000, 16'hffff}}, 1'b0);
      push_limb_pair({8{8'h0f}}, {8{8'hf0}}, 1'b1);
      // zero limbs inside a product, carry still has to flow
      push_limb_pair('0, '1, 1'b0);
      push_limb_pair('1, '0, 1'b0);
      push_limb_pair('1, '1, 1'b1);

      // random products, mostly short; a few run past the store depth so that
      // full-store drops happen both with and without the final mark
      while (pairs_sent < RANDOM_PAIRS) begin
         roll = $urandom_range(0, 99);
         if (product_count == 0)
            len = STORE_DEPTH + 2;
         else if (product_count == 7)
            len = STORE_DEPTH + 1;
         else if (product_count == 12)
            len = STORE_DEPTH;
         else if (roll < 70)
            len = $urandom_range(1, 5);
         else if (roll < 93)
            len = $urandom_range(6, 16);
         else
            len = $urandom_range(17, STORE_DEPTH + 4);
         no_idle <= ($urandom_range(0, 7) == 0);
         for (k = 0; k < len; k++)
            push_limb_pair(pick_limb(), pick_limb(), k == len - 1);
         pairs_sent += len;
         product_count++;
      end
      req_valid <= 1'b0;

      // drain, then give the block time to show any stray transfer
      while (products.waiting() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (products.errors == 0 && products.waiting() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> low_half_limb_multiplier.f
sv/lhlm_pkg.sv
sv/lhlm_limb_ram.sv
sv/lhlm_mac.sv
sv/lhlm_seq.sv
sv/low_half_limb_multiplier.sv
tb/sv/testbench.sv
